/* rtl/lst_pkg.sv */
// lst_pkg: shared types, constants and helpers for the Lisp source tokenizer.
// Holds the word formats of both channels, the front-to-back queue word,
// the scanner mode and character class enums and the keyword slot table.
package lst_pkg;

   // Position and line counters, saturating at all ones
   localparam int POS_BITS = 16;
   typedef logic [POS_BITS-1:0] pos_type;
   localparam pos_type POS_MAX = '1;

   // Keyword slot table: djb2 hash kept mod TABLE_SLOTS
   localparam int TABLE_SLOTS = 256;
   localparam int HASH_BITS   = $clog2(TABLE_SLOTS);
   typedef logic [HASH_BITS-1:0] hash_type;
   localparam hash_type HASH_SEED = hash_type'(5381 % TABLE_SLOTS);

   // Slots of the six keywords (djb2 of the spelling, mod 256)
   localparam hash_type HASH_DEFINE = 8'd112;
   localparam hash_type HASH_VAR    = 8'd206;
   localparam hash_type HASH_LAMBDA = 8'd6;
   localparam hash_type HASH_NIL    = 8'd200;
   localparam hash_type HASH_FALSE  = 8'd240;
   localparam hash_type HASH_TRUE   = 8'd229;

   // Front-to-back queue
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   // ASCII codes the scanner cares about
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [4:0] {
      KIND_PLUS    = 5'd0,
      KIND_MINUS   = 5'd1,
      KIND_STAR    = 5'd2,
      KIND_SLASH   = 5'd3,
      KIND_LPAREN  = 5'd4,
      KIND_RPAREN  = 5'd5,
      KIND_STRING  = 5'd6,
      KIND_INT     = 5'd7,
      KIND_FLOAT   = 5'd8,
      KIND_IDENT   = 5'd9,
      KIND_DEFINE  = 5'd10,
      KIND_VAR     = 5'd11,
      KIND_LAMBDA  = 5'd12,
      KIND_NIL     = 5'd13,
      KIND_FALSE   = 5'd14,
      KIND_TRUE    = 5'd15,
      KIND_EOF     = 5'd16,
      KIND_UNRECOG = 5'd17,
      KIND_UNTERM  = 5'd18
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_FRACTION,
      MODE_IDENT,
      MODE_STRING,
      MODE_COMMENT,
      MODE_ERROR
   } mode_type;

   typedef enum logic [3:0] {
      CLS_NEWLINE,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_STAR,
      CLS_SLASH,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_QUOTE,
      CLS_SEMI,
      CLS_DOT,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_source;
   } req_word_type;

   typedef struct packed {
      kind_type kind;
      pos_type  start_pos;
      pos_type  end_pos;
      pos_type  line_no;
      logic     final_of_run;
   } rsp_word_type;

   // Classified character as it travels from front to back
   typedef struct packed {
      logic [7:0]     ch;
      char_class_type cls;
      pos_type        pos;
      pos_type        nxt;
      logic           last;
   } fe_word_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : pos_type'(v + pos_type'(1));
   endfunction

   // h * 33 + c, mod 256
   function automatic hash_type hash_step(input hash_type h, input logic [7:0] c);
      return hash_type'(h << 5) + h + hash_type'(c);
   endfunction

   // Keyword slot table; empty slots read as a plain identifier
   function automatic kind_type kw_lookup(input hash_type h);
      kind_type k;
      unique case (h)
         HASH_DEFINE: k = KIND_DEFINE;
         HASH_VAR:    k = KIND_VAR;
         HASH_LAMBDA: k = KIND_LAMBDA;
         HASH_NIL:    k = KIND_NIL;
         HASH_FALSE:  k = KIND_FALSE;
         HASH_TRUE:   k = KIND_TRUE;
         default:     k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

/* rtl/lst_front.sv */
// lst_front: accepts source characters, classifies them and tracks position.
// Pushes one classified word per character into the queue. Uses lst_pkg.
module lst_front import lst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  logic         q_full,
   output logic         q_push,
   output fe_word_type  q_word
);

   pos_type pos_ff, pos_in;
   char_class_type cls;

   // Character classifier
   always_comb begin
      if (req_data.ch >= CH_ZERO && req_data.ch <= CH_NINE) begin
         cls = CLS_DIGIT;
      end else if ((req_data.ch >= CH_LOWER_A && req_data.ch <= CH_LOWER_Z) ||
                   (req_data.ch >= CH_UPPER_A && req_data.ch <= CH_UPPER_Z)) begin
         cls = CLS_ALPHA;
      end else begin
         unique case (req_data.ch)
            CH_NEWLINE:              cls = CLS_NEWLINE;
            CH_SPACE, CH_TAB, CH_CR: cls = CLS_SPACE;
            CH_PLUS:                 cls = CLS_PLUS;
            CH_MINUS:                cls = CLS_MINUS;
            CH_STAR:                 cls = CLS_STAR;
            CH_SLASH:                cls = CLS_SLASH;
            CH_LPAREN:               cls = CLS_LPAREN;
            CH_RPAREN:               cls = CLS_RPAREN;
            CH_QUOTE:                cls = CLS_QUOTE;
            CH_SEMI:                 cls = CLS_SEMI;
            CH_DOT:                  cls = CLS_DOT;
            default:                 cls = CLS_OTHER;
         endcase
      end
   end

   // Handshake into the queue
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign q_word = '{ch:   req_data.ch,
                     cls:  cls,
                     pos:  pos_ff,
                     nxt:  sat_inc(pos_ff),
                     last: req_data.end_of_source};

   // Position of the next character; restarts after the last one of a source
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = req_data.end_of_source ? '0 : sat_inc(pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/lst_queue.sv */
// lst_queue: short FIFO of classified words between front and back.
// Depth and pointer width come from lst_pkg.
module lst_queue import lst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fe_word_type push_word,
   output logic        full,
   output logic        head_valid,
   output fe_word_type head_word,
   input  logic        pop
);

   fe_word_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]      count_ff, count_in;

   assign full       = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_PTR_BITS+1)'(Q_DEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[Q_PTR_BITS-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

/* rtl/lst_back.sv */
// lst_back: scanner state machine and result buffer of the tokenizer.
// Takes one classified word per cycle once its result buffer drains, and releases
// its tokens one a cycle while rsp_ready is high. Uses lst_pkg.
module lst_back import lst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  fe_word_type  q_word,
   output logic         q_take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   mode_type     mode_ff, mode_in, mode_mid, fresh_mode;
   pos_type      begin_ff, begin_in, begin_mid;
   pos_type      line_ff, line_in, line_mid;
   hash_type     hash_ff, hash_in, hash_mid;
   rsp_word_type res_ff [3];
   rsp_word_type res_in [3];
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   idx_ff;
   logic         is_digit, is_alnum, fresh, failed;

   function automatic rsp_word_type make_tok(input kind_type k, input pos_type s,
                                             input pos_type e, input pos_type ln);
      return '{kind: k, start_pos: s, end_pos: e, line_no: ln, final_of_run: 1'b0};
   endfunction

   assign is_digit = (q_word.cls == CLS_DIGIT);
   assign is_alnum = is_digit || (q_word.cls == CLS_ALPHA);

   // Result buffer handshake: take a word when the buffer is empty or drains this cycle
   assign rsp_valid = (idx_ff != cnt_ff);
   assign q_take    = q_valid && ((idx_ff == cnt_ff) ||
                                  ((idx_ff + 2'd1 == cnt_ff) && rsp_ready));

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_data = res_ff[0];
         2'd1:    rsp_data = res_ff[1];
         default: rsp_data = res_ff[2];
      endcase
   end

   // Does this character start a token from scratch
   always_comb begin
      unique case (mode_ff)
         MODE_IDLE:     fresh = 1'b1;
         MODE_NUMBER:   fresh = !is_digit && (q_word.cls != CLS_DOT);
         MODE_FRACTION: fresh = !is_digit;
         MODE_IDENT:    fresh = !is_alnum;
         default:       fresh = 1'b0;
      endcase
   end

   always_comb begin
      unique case (q_word.cls)
         CLS_QUOTE:          fresh_mode = MODE_STRING;
         CLS_SEMI:           fresh_mode = MODE_COMMENT;
         CLS_DIGIT:          fresh_mode = MODE_NUMBER;
         CLS_ALPHA:          fresh_mode = MODE_IDENT;
         CLS_DOT, CLS_OTHER: fresh_mode = MODE_ERROR;
         default:            fresh_mode = MODE_IDLE;
      endcase
   end

   // Next scan mode
   always_comb begin
      mode_mid = mode_ff;
      unique case (mode_ff)
         MODE_NUMBER: begin
            if (fresh) begin
               mode_mid = fresh_mode;
            end else if (q_word.cls == CLS_DOT) begin
               mode_mid = MODE_FRACTION;
            end
         end
         MODE_IDLE, MODE_FRACTION, MODE_IDENT: begin
            if (fresh) mode_mid = fresh_mode;
         end
         MODE_STRING: begin
            if (q_word.cls == CLS_QUOTE) mode_mid = MODE_IDLE;
         end
         MODE_COMMENT: begin
            if (q_word.cls == CLS_NEWLINE) mode_mid = MODE_IDLE;
         end
         default: ;
      endcase
      mode_in = q_word.last ? MODE_IDLE : mode_mid;
   end

   // Tokens caused by this character, plus line, hash and start updates
   always_comb begin
      res_in[0] = '0;
      res_in[1] = '0;
      res_in[2] = '0;
      cnt_in    = 2'd0;
      failed    = 1'b0;
      line_mid  = line_ff;
      begin_mid = fresh ? q_word.pos : begin_ff;

      // closing the open token
      if (fresh && mode_ff == MODE_NUMBER) begin
         res_in[cnt_in] = make_tok(KIND_INT, begin_ff, q_word.pos, line_ff);
         cnt_in = cnt_in + 2'd1;
      end else if (fresh && mode_ff == MODE_FRACTION) begin
         res_in[cnt_in] = make_tok(KIND_FLOAT, begin_ff, q_word.pos, line_ff);
         cnt_in = cnt_in + 2'd1;
      end else if (fresh && mode_ff == MODE_IDENT) begin
         res_in[cnt_in] = make_tok(kw_lookup(hash_ff), begin_ff, q_word.pos, line_ff);
         cnt_in = cnt_in + 2'd1;
      end else if (mode_ff == MODE_STRING && q_word.cls == CLS_QUOTE) begin
         res_in[cnt_in] = make_tok(KIND_STRING, begin_ff, q_word.nxt, line_ff);
         cnt_in = cnt_in + 2'd1;
      end

      if (mode_ff == MODE_COMMENT && q_word.cls == CLS_NEWLINE) begin
         line_mid = sat_inc(line_ff);
      end

      // running hash
      hash_mid = hash_ff;
      if (mode_ff == MODE_IDENT && is_alnum) begin
         hash_mid = hash_step(hash_ff, q_word.ch);
      end else if (fresh && q_word.cls == CLS_ALPHA) begin
         hash_mid = hash_step(HASH_SEED, q_word.ch);
      end else if (fresh && mode_ff == MODE_IDENT) begin
         hash_mid = HASH_SEED;
      end

      // character scanned from scratch
      if (fresh) begin
         unique case (q_word.cls)
            CLS_NEWLINE: line_mid = sat_inc(line_ff);
            CLS_PLUS, CLS_MINUS, CLS_STAR, CLS_SLASH, CLS_LPAREN, CLS_RPAREN,
            CLS_DOT, CLS_OTHER: begin
               unique case (q_word.cls)
                  CLS_PLUS:   res_in[cnt_in] = make_tok(KIND_PLUS, q_word.pos,
                                                        q_word.nxt, line_mid);
                  CLS_MINUS:  res_in[cnt_in] = make_tok(KIND_MINUS, q_word.pos,
                                                        q_word.nxt, line_mid);
                  CLS_STAR:   res_in[cnt_in] = make_tok(KIND_STAR, q_word.pos,
                                                        q_word.nxt, line_mid);
                  CLS_SLASH:  res_in[cnt_in] = make_tok(KIND_SLASH, q_word.pos,
                                                        q_word.nxt, line_mid);
                  CLS_LPAREN: res_in[cnt_in] = make_tok(KIND_LPAREN, q_word.pos,
                                                        q_word.nxt, line_mid);
                  CLS_RPAREN: res_in[cnt_in] = make_tok(KIND_RPAREN, q_word.pos,
                                                        q_word.nxt, line_mid);
                  default:    res_in[cnt_in] = make_tok(KIND_UNRECOG, q_word.pos,
                                                        q_word.nxt, line_mid);
               endcase
               cnt_in = cnt_in + 2'd1;
            end
            default: ;
         endcase
      end

      // end of source: flush the open token, then EOF unless an error was seen
      line_in  = line_mid;
      hash_in  = hash_mid;
      begin_in = begin_mid;
      if (q_word.last) begin
         unique case (mode_mid)
            MODE_NUMBER: begin
               res_in[cnt_in] = make_tok(KIND_INT, begin_mid, q_word.nxt, line_mid);
               cnt_in = cnt_in + 2'd1;
            end
            MODE_FRACTION: begin
               res_in[cnt_in] = make_tok(KIND_FLOAT, begin_mid, q_word.nxt, line_mid);
               cnt_in = cnt_in + 2'd1;
            end
            MODE_IDENT: begin
               res_in[cnt_in] = make_tok(kw_lookup(hash_mid), begin_mid, q_word.nxt,
                                         line_mid);
               cnt_in = cnt_in + 2'd1;
            end
            MODE_STRING: begin
               res_in[cnt_in] = make_tok(KIND_UNTERM, begin_mid, q_word.nxt, line_mid);
               cnt_in = cnt_in + 2'd1;
               failed = 1'b1;
            end
            MODE_ERROR: failed = 1'b1;
            default: ;
         endcase
         if (!failed) begin
            res_in[cnt_in] = make_tok(KIND_EOF, q_word.nxt, q_word.nxt, line_mid);
            cnt_in = cnt_in + 2'd1;
         end
         line_in  = '0;
         hash_in  = HASH_SEED;
         begin_in = '0;
      end

      // mark the last token of this character
      for (int k = 0; k < 3; k++) begin
         res_in[k].final_of_run = (2'(k) + 2'd1 == cnt_in);
      end
   end

   // Scanner state and buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         begin_ff <= '0;
         line_ff  <= '0;
         hash_ff  <= HASH_SEED;
         cnt_ff   <= 2'd0;
         idx_ff   <= 2'd0;
      end else if (q_take) begin
         mode_ff  <= mode_in;
         begin_ff <= begin_in;
         line_ff  <= line_in;
         hash_ff  <= hash_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         idx_ff   <= idx_ff + 2'd1;
      end
   end

   // Token words
   always_ff @(posedge clock) begin
      if (q_take) begin
         res_ff <= res_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("result index ran past the buffered count");

   a_final_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.final_of_run == (idx_ff + 2'd1 == cnt_ff)))
      else $error("final flag not on the last buffered token");

   a_source_restart: assert property (@(posedge clock) disable iff (reset)
      (q_take && q_word.last) |=>
         (mode_ff == MODE_IDLE && line_ff == '0 && hash_ff == HASH_SEED))
      else $error("scanner state not restarted after end of source");

endmodule

/* rtl/lisp_source_tokenizer.sv */
// lisp_source_tokenizer: top level of the streaming Lisp tokenizer.
// Instantiates lst_front, lst_queue and lst_back; types from lst_pkg.
//
// Usage:
//   req channel: one source character per word (ch, end_of_source), with
//   end_of_source set on the final character of each source text.
//   rsp channel: token words (kind, start_pos, end_pos, line_no,
//   final_of_run); final_of_run marks the last token a character caused.
//   A character produces zero to three tokens.
// Timing:
//   A character passes through a queue slot register, then the scanner's result
//   buffer register, before its tokens are offered on rsp.
//   Throughput is one character per cycle while each gives at most one token
//   and rsp_ready stays high; a character that gives more tokens holds the
//   scanner until its result buffer has released them, one token per cycle.
//   Keyword lookup is a combinational read of a constant 256-slot table.
// Stalls:
//   While rsp_ready is low the scanner holds its buffered tokens and the
//   front keeps accepting until its four-word queue is full, then drops
//   req_ready.
// Reset:
//   Clears the queue and the scanner (idle mode, position and line zero,
//   hash seed). No clearing pass; characters are taken straight away.
module lisp_source_tokenizer import lst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic        q_push, q_full, q_valid, q_take;
   fe_word_type push_word, head_word;

   lst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_word    (push_word)
   );

   lst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_word  (push_word),
      .full       (q_full),
      .head_valid (q_valid),
      .head_word  (head_word),
      .pop        (q_take)
   );

   lst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (head_word),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
